[rtl/mcts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcts_pkg
// Shared types, codes and token tables for the charset token sniffer.
// ----------------------------------------------------------------------------
package mcts_pkg;

	// Result kinds
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_NAME = 2'd0;
	localparam kind_t KIND_DONE = 2'd1;
	localparam kind_t KIND_NONE = 2'd2;

	// Sequence selection codes
	localparam logic SEQ_META  = 1'b0;
	localparam logic SEQ_EQUIV = 1'b1;

	// Largest number of tokens honoured in one sequence
	localparam int TOKENS_MAX = 8;
	// Largest number of tokens held in the table for one sequence
	localparam int TOKEN_ROWS = 6;

	typedef logic [2:0] tok_idx_t;
	typedef logic [3:0] char_idx_t;

	// Byte belongs to a word: letter, digit, slash or hyphen
	function automatic logic is_word_byte(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9") || c == "/" || c == "-";
	endfunction

	// Fold upper case to lower case
	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	// Number of tokens in the selected sequence
	function automatic logic [2:0] seq_count(input logic sel);
		return (sel == SEQ_EQUIV) ? 3'd6 : 3'd2;
	endfunction

	// Token text, right-aligned, and its length
	function automatic logic [99:0] tok_entry(input logic sel, input tok_idx_t tok);
		logic [95:0] s;
		logic [3:0]  len;
		s   = '0;
		len = '0;
		case ({sel, tok})
			{SEQ_META,  3'd0}: begin s = 96'("meta");         len = 4'd4;  end
			{SEQ_META,  3'd1}: begin s = 96'("charset");      len = 4'd7;  end
			{SEQ_EQUIV, 3'd0}: begin s = 96'("meta");         len = 4'd4;  end
			{SEQ_EQUIV, 3'd1}: begin s = 96'("http-equiv");   len = 4'd10; end
			{SEQ_EQUIV, 3'd2}: begin s = 96'("content-type"); len = 4'd12; end
			{SEQ_EQUIV, 3'd3}: begin s = 96'("content");      len = 4'd7;  end
			{SEQ_EQUIV, 3'd4}: begin s = 96'("text/html");    len = 4'd9;  end
			{SEQ_EQUIV, 3'd5}: begin s = 96'("charset");      len = 4'd7;  end
			default:           begin s = '0;                  len = 4'd0;  end
		endcase
		return {len, s};
	endfunction

	function automatic logic [3:0] tok_len(input logic sel, input tok_idx_t tok);
		logic [99:0] e;
		e = tok_entry(sel, tok);
		return e[99:96];
	endfunction

	// Character at position idx (from the left) of a token; idx below length
	function automatic logic [7:0] tok_char(input logic sel, input tok_idx_t tok,
			input char_idx_t idx);
		logic [99:0] e;
		logic [3:0]  sh;
		logic [95:0] s;
		e  = tok_entry(sel, tok);
		sh = e[99:96] - idx - 4'd1;
		s  = e[95:0] >> {sh, 3'b000};
		return s[7:0];
	endfunction

endpackage

[rtl/mcts_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcts_ifs
// Handshake channels of the charset token sniffer: document bytes in,
// result words out.
// ----------------------------------------------------------------------------
interface mcts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_buffer;

	modport source (output valid, in_byte, end_of_buffer, input ready);
	modport sink   (input valid, in_byte, end_of_buffer, output ready);
endinterface

interface mcts_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       last;

	modport source (output valid, out_byte, kind, last, input ready);
	modport sink   (input valid, out_byte, kind, last, output ready);
endinterface

[rtl/meta_charset_token_sniffer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meta_charset_token_sniffer_unit
// Scans document bytes for a charset declaration and streams out its name.
// ----------------------------------------------------------------------------
// Usage:
//   bytes   : one document byte per word, end_of_buffer on the last byte.
//   results : name bytes (kind 0), then name complete (kind 1, last), or
//             not found (kind 2, last) when the buffer ends first; name bytes
//             already sent are then void.
//   cfg_we / cfg_wdata : selects the short meta/charset sequence (0) or the
//             http-equiv content-type sequence (1); write only while idle.
// Timing:
//   One byte per cycle while results.ready stays high. A byte is held in the input
//   register, then classified, compared against one character of the token
//   table and its result registered in the result register.
// Reset:
//   arst_n clears the search state, the selection register and both stage
//   valids; no clearing pass is needed.
// Stall:
//   The result register holds while results.ready is low; the input stage takes
//   at most one more byte and then drops bytes.ready until the result moves.
// ----------------------------------------------------------------------------
module meta_charset_token_sniffer_unit #(
	parameter int TOKEN_LEN_MAX = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	mcts_in_if.sink    bytes,
	mcts_out_if.source results,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);
	import mcts_pkg::*;

	localparam int WL_W = $clog2(TOKEN_LEN_MAX + 1);

	localparam logic [1:0] PH_SEARCH = 2'd0;
	localparam logic [1:0] PH_NAME   = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	// Configuration
	logic sel_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;

	// Search state
	logic [1:0]      phase_q;
	tok_idx_t        tok_q;
	logic            begun_q;
	logic            in_word_q;
	logic [WL_W-1:0] wl_q;
	logic            differs_q;
	logic            angle_q;
	logic [7:0]      prior_q;

	// Result stage
	logic       valid_s2;
	logic [7:0] byte_s2;
	kind_t      kind_s2;
	logic       last_s2;

	logic fire_s1;

	// Next-state and result
	logic [1:0]      phase_d;
	tok_idx_t        tok_d;
	logic            begun_d;
	logic            in_word_d;
	logic [WL_W-1:0] wl_d;
	logic            differs_d;
	logic            angle_d;
	logic            res_v;
	logic [7:0]      res_byte;
	kind_t           res_kind;

	logic            word_b;
	logic            tok_ok;
	logic [3:0]      tlen;
	logic [WL_W-1:0] wl_eff;
	logic [7:0]      wl8;
	logic [7:0]      wlq8;
	logic [7:0]      tchar;
	logic            equal;

	assign fire_s1       = valid_s1 && (!valid_s2 || results.ready);
	assign bytes.ready   = !valid_s1 || fire_s1;

	assign results.valid    = valid_s2;
	assign results.out_byte = byte_s2;
	assign results.kind     = kind_s2;
	assign results.last     = last_s2;

	// Hold the sequence selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= SEQ_META;
		end else if (cfg_we) begin
			sel_q <= cfg_wdata;
		end
	end

	// Register the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.in_byte;
			eob_s1  <= bytes.end_of_buffer;
		end
	end

	// Classify the byte and compare it against the current token
	always_comb begin
		word_b  = is_word_byte(byte_s1);
		tok_ok  = (tok_q < seq_count(sel_q)) && (32'(tok_q) < TOKENS_MAX) &&
			(32'(tok_q) < TOKEN_ROWS);
		tlen    = tok_len(sel_q, tok_q);
		wl_eff  = in_word_q ? wl_q : '0;
		wl8     = 8'(wl_eff);
		wlq8    = 8'(wl_q);
		tchar   = tok_char(sel_q, tok_q, wl8[3:0]);
		equal   = tok_ok && !differs_q && (wlq8 == 8'(tlen));

		phase_d   = phase_q;
		tok_d     = tok_q;
		begun_d   = begun_q;
		in_word_d = in_word_q;
		wl_d      = wl_q;
		differs_d = differs_q;
		angle_d   = angle_q;
		res_v     = 1'b0;
		res_byte  = '0;
		res_kind  = KIND_NAME;

		case (phase_q)
			PH_SEARCH: begin
				if (word_b) begin
					in_word_d = 1'b1;
					if (!in_word_q) begin
						angle_d = (prior_q == "<");
					end
					differs_d = (in_word_q && differs_q) || !tok_ok ||
						!(wl8 < 8'(tlen)) || (to_lower(byte_s1) != tchar);
					wl_d = (wl8 < 8'(TOKEN_LEN_MAX)) ? WL_W'(wl_eff + 1'b1) : wl_eff;
				end else if (in_word_q) begin
					in_word_d = 1'b0;
					if (equal) begin
						if (begun_q || angle_q) begin
							begun_d = 1'b1;
							tok_d   = tok_q + 3'd1;
							if (tok_d >= seq_count(sel_q)) begin
								phase_d = PH_NAME;
							end
						end
					end else if (begun_q) begin
						begun_d = 1'b0;
						tok_d   = '0;
					end
				end
			end
			PH_NAME: begin
				if (word_b) begin
					in_word_d = 1'b1;
					res_v     = 1'b1;
					res_byte  = byte_s1;
					res_kind  = KIND_NAME;
				end else if (in_word_q) begin
					in_word_d = 1'b0;
					phase_d   = PH_DONE;
					res_v     = 1'b1;
					res_kind  = KIND_DONE;
				end
			end
			default: begin
				// done: ignore bytes until the buffer ends
			end
		endcase

		// Close the search at buffer end
		if (eob_s1) begin
			if (phase_d != PH_DONE) begin
				res_v    = 1'b1;
				res_byte = '0;
				res_kind = KIND_NONE;
			end
		end
	end

	// Advance the search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SEARCH;
			tok_q     <= '0;
			begun_q   <= 1'b0;
			in_word_q <= 1'b0;
			wl_q      <= '0;
			differs_q <= 1'b0;
			angle_q   <= 1'b0;
			prior_q   <= '0;
		end else if (fire_s1) begin
			if (eob_s1) begin
				phase_q   <= PH_SEARCH;
				tok_q     <= '0;
				begun_q   <= 1'b0;
				in_word_q <= 1'b0;
				wl_q      <= '0;
				differs_q <= 1'b0;
				angle_q   <= 1'b0;
				prior_q   <= '0;
			end else begin
				phase_q   <= phase_d;
				tok_q     <= tok_d;
				begun_q   <= begun_d;
				in_word_q <= in_word_d;
				wl_q      <= wl_d;
				differs_q <= differs_d;
				angle_q   <= angle_d;
				prior_q   <= byte_s1;
			end
		end
	end

	// Load or drain the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			valid_s2 <= res_v;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res_v) begin
			byte_s2 <= res_byte;
			kind_s2 <= res_kind;
			last_s2 <= (res_kind != KIND_NAME);
		end
	end

	// Checks
	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SEARCH || phase_q == PH_NAME || phase_q == PH_DONE)
		else $error("search phase left its codes");

	a_eob_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && eob_s1) |=> (phase_q == PH_SEARCH && tok_q == '0 &&
			!in_word_q && !begun_q && prior_q == '0))
		else $error("buffer end did not clear the search");

	a_name_byte_class: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2 == KIND_NAME) |-> is_word_byte(byte_s2))
		else $error("name byte outside the word class");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (last_s2 == (kind_s2 != KIND_NAME)))
		else $error("last flag disagrees with kind");

	a_name_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && res_v && res_kind == KIND_DONE) |-> phase_q == PH_NAME)
		else $error("name complete outside the name phase");

endmodule

[sim/mcts_sniff_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcts_sniff_checker
// Watches the byte and result channels of the charset token sniffer, keeps
// its own model of the token search, and compares every result word with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
package mcts_sniff_tb_pkg;
	import mcts_pkg::*;

	// One predicted or observed result word
	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} sniff_result_t;

	// Letter, digit, slash or hyphen
	function automatic logic is_word_char(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39) || c == 8'h2F || c == 8'h2D;
	endfunction

	// Tokens in the chosen sequence
	function automatic int seq_len(input logic sel);
		return (sel == SEQ_EQUIV) ? 6 : 2;
	endfunction

	// Text of one token, lower case; empty beyond the end of the sequence
	function automatic string token_text(input logic sel, input int idx);
		string t;
		t = "";
		if (sel == SEQ_EQUIV) begin
			case (idx)
				0: t = "meta";
				1: t = "http-equiv";
				2: t = "content-type";
				3: t = "content";
				4: t = "text/html";
				5: t = "charset";
				default: t = "";
			endcase
		end else begin
			case (idx)
				0: t = "meta";
				1: t = "charset";
				default: t = "";
			endcase
		end
		return t;
	endfunction
endpackage

module mcts_sniff_checker #(
	parameter int TOKEN_LEN_MAX = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_buffer,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic [1:0] kind,
	input  logic       last,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	output int         fail_count,
	output int         pending,
	output int         names_done,
	output int         names_missed,
	output int         name_bytes
);
	import mcts_pkg::*;
	import mcts_sniff_tb_pkg::*;

	typedef enum logic [1:0] {PH_SEARCH, PH_NAME, PH_DONE} sniff_phase_e;

	sniff_result_t expected_results[$];

	// Model copy of the search state and the selection register
	sniff_phase_e phase;
	int           tok_num;
	int           word_len;
	logic         begun;
	logic         in_word;
	logic         word_bad;
	logic         after_angle;
	logic [7:0]   prev_byte;
	logic         seq_sel;

	task automatic clear_search();
		phase       = PH_SEARCH;
		tok_num     = 0;
		word_len    = 0;
		begun       = 1'b0;
		in_word     = 1'b0;
		word_bad    = 1'b0;
		after_angle = 1'b0;
		prev_byte   = 8'h00;
	endtask

	task automatic report_field(input string field, input int exp_v, input int act_v);
		fail_count++;
		$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
	endtask

	// Advance the model by one document byte and queue any result it causes
	task automatic predict_sniff(input logic [7:0] c, input logic eob);
		string         tok;
		logic          tok_ok;
		logic          matched;
		logic [7:0]    lc;
		logic          emit;
		sniff_result_t r;
		tok    = token_text(seq_sel, tok_num);
		tok_ok = (tok_num < seq_len(seq_sel)) && (tok_num < TOKENS_MAX) &&
			(tok_num < TOKEN_ROWS);
		emit   = 1'b0;
		r.data = 8'h00;
		r.kind = KIND_NAME;
		r.last = 1'b0;
		case (phase)
			PH_SEARCH: begin
				if (is_word_char(c)) begin
					// open a new word and note whether '<' preceded it
					if (!in_word) begin
						in_word     = 1'b1;
						word_len    = 0;
						word_bad    = 1'b0;
						after_angle = (prev_byte == 8'h3C);
					end
					if (tok_ok && word_len < tok.len()) begin
						lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
						if (lc != tok[word_len])
							word_bad = 1'b1;
					end else begin
						word_bad = 1'b1;
					end
					if (word_len < TOKEN_LEN_MAX)
						word_len++;
				end else if (in_word) begin
					// word ended: step the sequence on a match, restart on a miss
					matched = tok_ok && !word_bad && word_len == tok.len();
					in_word = 1'b0;
					if (matched) begin
						if (begun || after_angle) begin
							begun = 1'b1;
							tok_num++;
							if (tok_num >= seq_len(seq_sel))
								phase = PH_NAME;
						end
					end else if (begun) begin
						begun   = 1'b0;
						tok_num = 0;
					end
				end
			end
			PH_NAME: begin
				if (is_word_char(c)) begin
					in_word = 1'b1;
					r.data  = c;
					emit    = 1'b1;
				end else if (in_word) begin
					in_word = 1'b0;
					phase   = PH_DONE;
					r.kind  = KIND_DONE;
					r.last  = 1'b1;
					emit    = 1'b1;
				end
			end
			default: begin
			end
		endcase
		prev_byte = c;

		// buffer end: report not found unless the name has completed
		if (eob) begin
			if (phase != PH_DONE && !(emit && r.kind == KIND_DONE)) begin
				r.data = 8'h00;
				r.kind = KIND_NONE;
				r.last = 1'b1;
				emit   = 1'b1;
			end
			clear_search();
		end
		if (emit)
			expected_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		sniff_result_t want;
		if (!arst_n) begin
			clear_search();
			seq_sel = SEQ_META;
			expected_results.delete();
			fail_count   = 0;
			names_done   = 0;
			names_missed = 0;
			name_bytes   = 0;
		end else begin
			if (cfg_we)
				seq_sel = cfg_wdata;

			// compare a delivered result word with the oldest prediction
			if (out_valid && out_ready) begin
				case (kind)
					KIND_NAME: name_bytes++;
					KIND_DONE: names_done++;
					default:   names_missed++;
				endcase
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t ns: unexpected result, expected none,%s",
						$time, " got:");
					$display("    byte %02h kind %0d last %0b", out_byte, kind, last);
				end else begin
					want = expected_results.pop_front();
					if (out_byte !== want.data)
						report_field("out_byte", int'(want.data), int'(out_byte));
					if (kind !== want.kind)
						report_field("kind", int'(want.kind), int'(kind));
					if (last !== want.last)
						report_field("last", int'(want.last), int'(last));
				end
			end

			if (in_valid && in_ready)
				predict_sniff(in_byte, end_of_buffer);
		end
		pending = expected_results.size();
	end

endmodule

[sim/meta_charset_token_sniffer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meta_charset_token_sniffer_unit_tb
// Feeds short documents to the charset token sniffer: a few directed buffers,
// then random buffers that are mostly well-formed declarations for either
// sequence, mixed with broken tokens and noise. The sender runs in bursts,
// the receiver stalls on a changing pattern, and the selection register is
// rewritten between buffers and in the middle of a search.
// ----------------------------------------------------------------------------
module meta_charset_token_sniffer_unit_tb;
	import mcts_pkg::*;
	import mcts_sniff_tb_pkg::*;

	localparam int RANDOM_ITEMS = 1050;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_GAP    = 6;
	localparam int TAIL_CYCLES  = 8;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	mcts_in_if  bytes_if ();
	mcts_out_if results_if ();

	int chk_fail;
	int chk_pending;
	int chk_done;
	int chk_missed;
	int chk_name_bytes;

	logic [7:0] doc_q[$];
	logic       cur_sel;
	int         n_sent;
	int         n_docs;
	int         n_cfg;
	int         burst_left;

	meta_charset_token_sniffer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (bytes_if),
		.results   (results_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	mcts_sniff_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (bytes_if.valid),
		.in_ready      (bytes_if.ready),
		.in_byte       (bytes_if.in_byte),
		.end_of_buffer (bytes_if.end_of_buffer),
		.out_valid     (results_if.valid),
		.out_ready     (results_if.ready),
		.out_byte      (results_if.out_byte),
		.kind          (results_if.kind),
		.last          (results_if.last),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (chk_fail),
		.pending       (chk_pending),
		.names_done    (chk_done),
		.names_missed  (chk_missed),
		.name_bytes    (chk_name_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random letter, digit, slash or hyphen
	function automatic logic [7:0] rand_word_char();
		logic [7:0] c;
		case ($urandom_range(0, 5))
			0: c = 8'($urandom_range(8'h41, 8'h5A));
			1: c = 8'($urandom_range(8'h30, 8'h39));
			2: c = 8'h2F;
			3: c = 8'h2D;
			default: c = 8'($urandom_range(8'h61, 8'h7A));
		endcase
		return c;
	endfunction

	task automatic push_text(input string s);
		int k;
		for (k = 0; k < s.len(); k++)
			doc_q.push_back(s[k]);
	endtask

	// Append one to three bytes that end a word
	task automatic add_sep();
		logic [7:0] c;
		repeat ($urandom_range(1, 3)) begin
			case ($urandom_range(0, 4))
				0: c = 8'h20;
				1: c = 8'h3D;
				2: c = 8'h22;
				3: c = 8'h3B;
				default: begin
					c = 8'($urandom_range(0, 255));
					while (is_word_char(c))
						c = 8'($urandom_range(0, 255));
				end
			endcase
			doc_q.push_back(c);
		end
	endtask

	task automatic add_noise();
		repeat ($urandom_range(1, 6))
			doc_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// Append a token in random case, optionally spoilt
	task automatic add_token(input string t, input bit mutate);
		int         k;
		int         m;
		int         pos;
		logic [7:0] c;
		m   = mutate ? $urandom_range(0, 3) : 4;
		pos = $urandom_range(0, t.len() - 1);
		for (k = 0; k < t.len(); k++) begin
			// drop the final letter
			if (m == 2 && k == t.len() - 1)
				continue;
			c = t[k];
			if (m == 0 && k == pos)
				c = rand_word_char();
			if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1))
				c = c - 8'd32;
			doc_q.push_back(c);
		end
		if (m == 1)
			doc_q.push_back(rand_word_char());
		if (m == 3)
			repeat ($urandom_range(8, 16)) doc_q.push_back(rand_word_char());
	endtask

	task automatic add_any_token(input bit mutate);
		logic s;
		s = 1'($urandom_range(0, 1));
		add_token(token_text(s, $urandom_range(0, seq_len(s) - 1)), mutate);
	endtask

	// Build one document; split marks where the register flips mid-search
	task automatic build_doc(output int split);
		int   style;
		int   i;
		logic tgt;
		split = -1;
		doc_q.delete();
		style = $urandom_range(0, 9);
		if (style < 7) begin
			// leading clutter
			repeat ($urandom_range(0, 2)) begin
				if ($urandom_range(0, 1))
					add_noise();
				else
					add_any_token(1'($urandom_range(0, 1)));
				add_sep();
			end
			tgt = ($urandom_range(0, 4) == 0) ? ~cur_sel : cur_sel;
			if ($urandom_range(0, 9) != 0)
				doc_q.push_back(8'h3C);
			for (i = 0; i < seq_len(tgt); i++) begin
				if (i > 0) begin
					add_sep();
					if (split < 0 && $urandom_range(0, 11) == 0)
						split = doc_q.size();
				end
				add_token(token_text(tgt, i), $urandom_range(0, 9) == 0);
			end
			add_sep();
			// charset name, mostly short
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(13, 24)) doc_q.push_back(rand_word_char());
			else
				repeat ($urandom_range(1, 10)) doc_q.push_back(rand_word_char());
			case ($urandom_range(0, 3))
				0: begin
				end
				1: doc_q.push_back(8'h22);
				default: begin
					add_sep();
					if ($urandom_range(0, 1))
						add_any_token(1'b0);
					add_noise();
				end
			endcase
		end else if (style < 9) begin
			// broken declarations
			repeat ($urandom_range(1, 5)) begin
				case ($urandom_range(0, 3))
					0: doc_q.push_back(8'h3C);
					1: add_noise();
					default: add_any_token($urandom_range(0, 2) == 0);
				endcase
				add_sep();
			end
		end else begin
			repeat ($urandom_range(1, 12))
				doc_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Offer one word, maybe idling first when the current burst is spent
	task automatic push_byte(input logic [7:0] b, input logic eob);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				bytes_if.valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		bytes_if.valid         <= 1'b1;
		bytes_if.in_byte       <= b;
		bytes_if.end_of_buffer <= eob;
		@(posedge clk);
		while (!bytes_if.ready)
			@(posedge clk);
	endtask

	// Hold the sender until every predicted result has been delivered
	task automatic drain();
		@(negedge clk);
		bytes_if.valid <= 1'b0;
		while (chk_pending != 0)
			@(negedge clk);
	endtask

	task automatic set_sequence(input logic v);
		drain();
		repeat (DRAIN_GAP) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_sel = v;
		n_cfg++;
	endtask

	task automatic send_doc(input int split);
		int i;
		for (i = 0; i < doc_q.size(); i++) begin
			if (i == split)
				set_sequence(~cur_sel);
			push_byte(doc_q[i], i == doc_q.size() - 1);
			n_sent++;
		end
		n_docs++;
	endtask

	// Receiver: drive ready by a stall pattern that is chosen anew at random
	initial begin : rx_pattern
		int   cyc;
		int   mode;
		int   k;
		int   hold;
		logic rdy;
		results_if.ready = 1'b0;
		cyc  = 0;
		mode = 0;
		k    = 2;
		hold = 0;
		forever begin
			@(negedge clk);
			if (cyc % 150 == 0) begin
				mode = $urandom_range(0, 3);
				k    = $urandom_range(2, 5);
			end
			cyc++;
			case (mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(0, 1));
				2: rdy = (cyc % k) == 0;
				default: begin
					if (hold > 0) begin
						hold--;
						rdy = 1'b0;
					end else begin
						rdy = 1'b1;
						if ($urandom_range(0, 9) == 0)
							hold = $urandom_range(1, 8);
					end
				end
			endcase
			results_if.ready <= rdy;
		end
	end

	// Abort when nothing moves on either channel for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (bytes_if.valid && bytes_if.ready) ||
					(results_if.valid && results_if.ready))
				idle = 0;
			else
				idle++;
		end
		$display("FAIL meta_charset_token_sniffer_unit");
		$finish;
	end

	initial begin : stimulus
		int split;
		int target;
		bytes_if.valid         = 1'b0;
		bytes_if.in_byte       = 8'h00;
		bytes_if.end_of_buffer = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = SEQ_META;
		arst_n     = 1'b0;
		cur_sel    = SEQ_META;
		n_sent     = 0;
		n_docs     = 0;
		n_cfg      = 0;
		burst_left = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		set_sequence(SEQ_META);

		// name cut short by the buffer end, mixed case, top byte as separator
		doc_q.delete();
		push_text("<mEtA");
		doc_q.push_back(8'hFF);
		push_text("Charset=x9");
		send_doc(-1);
		// lone zero byte as a whole buffer
		doc_q.delete();
		doc_q.push_back(8'h00);
		send_doc(-1);
		// word at buffer start, no '<' in front
		doc_q.delete();
		push_text("Z/-");
		send_doc(-1);

		set_sequence(SEQ_EQUIV);

		target = n_sent + RANDOM_ITEMS;
		while (n_sent < target) begin
			if ($urandom_range(0, 9) == 0)
				set_sequence(1'($urandom_range(0, 1)));
			build_doc(split);
			send_doc(split);
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d bytes in %0d buffers with %0d sequence register writes.",
			n_sent, n_docs, n_cfg);
		$display("Seen %0d name bytes, %0d names complete, %0d not found.",
			chk_name_bytes, chk_done, chk_missed);
		if (chk_fail == 0)
			$display("PASS meta_charset_token_sniffer_unit");
		else
			$display("FAIL meta_charset_token_sniffer_unit");
		$finish;
	end

endmodule
